// File: src/dllm_pkg.sv
// Shared types, constants and the control store of the linked list manager.
// Holds the request codes, the control word layout, the dispatch table and
// the microprogram ROM. Depends on nothing.
package dllm_pkg;

  localparam int unsigned NODE_W         = 6;
  localparam int unsigned REQ_W          = 3;
  localparam int unsigned UPC_W          = 5;
  localparam int unsigned POOL_NODES_DEF = 64;
  localparam int unsigned S_TDATA_W      = 16;
  localparam int unsigned M_TDATA_W      = 32;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [UPC_W-1:0]  upc_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_FIRST    = 3'd0,
    REQ_ADD_LAST     = 3'd1,
    REQ_REMOVE_FIRST = 3'd2,
    REQ_INSERT_AFTER = 3'd3,
    REQ_UNLINK       = 3'd4,
    REQ_REMOVE_ALL   = 3'd5,
    REQ_NODE_INIT    = 3'd6,
    REQ_NEIGHBOURS   = 3'd7
  } req_e;

  typedef enum logic [3:0] {
    SRC_ZERO = 4'd0,
    SRC_N    = 4'd1,
    SRC_A    = 4'd2,
    SRC_T    = 4'd3,
    SRC_HN   = 4'd4,
    SRC_HP   = 4'd5,
    SRC_RDN  = 4'd6,
    SRC_RDP  = 4'd7,
    SRC_Y    = 4'd8
  } src_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_e;

  typedef enum logic [1:0] {
    RES_NONE    = 2'd0,
    RES_REMOVED = 2'd1,
    RES_NBR     = 2'd2,
    RES_EMPTY   = 2'd3
  } res_e;

  typedef enum logic [2:0] {
    SEQ_NEXT     = 3'd0,
    SEQ_GOTO     = 3'd1,
    SEQ_KZERO    = 3'd2,
    SEQ_DISPATCH = 3'd3,
    SEQ_RETIRE   = 3'd4
  } seq_e;

  typedef struct packed {
    src_e rd_src;
    logic nw_en;
    src_e nw_addr;
    src_e nw_data;
    logic pw_en;
    src_e pw_addr;
    src_e pw_data;
    logic t_ld;
    src_e t_src;
    cnt_e cnt_op;
    logic k_ld;
    logic k_dec;
    res_e res_op;
  } dp_op_t;

  typedef struct packed {
    seq_e   seq;
    upc_t   target;
    dp_op_t op;
  } uword_t;

  typedef struct packed {
    logic   fetch;
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    logic busy;
    logic cnt_zero;
    logic k_zero;
  } stat_t;

  typedef struct packed {
    node_t node_out;
    node_t next_out;
    node_t first_node;
    node_t last_node;
    node_t node_count;
    logic  empty_flag;
  } res_t;

  localparam upc_t UPC_FETCH = 5'd0;
  localparam upc_t UPC_AF1   = 5'd1;
  localparam upc_t UPC_AF2   = 5'd2;
  localparam upc_t UPC_AL1   = 5'd3;
  localparam upc_t UPC_AL2   = 5'd4;
  localparam upc_t UPC_RF1   = 5'd5;
  localparam upc_t UPC_RF2   = 5'd6;
  localparam upc_t UPC_RFE   = 5'd7;
  localparam upc_t UPC_IA1   = 5'd8;
  localparam upc_t UPC_IA2   = 5'd9;
  localparam upc_t UPC_IA3   = 5'd10;
  localparam upc_t UPC_UL1   = 5'd11;
  localparam upc_t UPC_UL2   = 5'd12;
  localparam upc_t UPC_RA0   = 5'd13;
  localparam upc_t UPC_RA1   = 5'd14;
  localparam upc_t UPC_RA2   = 5'd15;
  localparam upc_t UPC_RA3   = 5'd16;
  localparam upc_t UPC_NI1   = 5'd17;
  localparam upc_t UPC_NB1   = 5'd18;
  localparam upc_t UPC_NB2   = 5'd19;
  localparam upc_t UPC_DONE  = 5'd20;

  function automatic logic in_pool(node_t v, int unsigned pool);
    return 32'(v) < pool;
  endfunction

  function automatic upc_t dispatch(req_e kind, logic npool, logic apool, logic nzero,
                                    logic cnt_zero);
    logic nok;
    upc_t pc;
    nok = npool && !nzero;
    case (kind)
      REQ_ADD_FIRST:    pc = nok ? UPC_AF1 : UPC_DONE;
      REQ_ADD_LAST:     pc = nok ? UPC_AL1 : UPC_DONE;
      REQ_REMOVE_FIRST: pc = cnt_zero ? UPC_RFE : UPC_RF1;
      REQ_INSERT_AFTER: pc = (nok && apool) ? UPC_IA1 : UPC_DONE;
      REQ_UNLINK:       pc = nok ? UPC_UL1 : UPC_DONE;
      REQ_REMOVE_ALL:   pc = UPC_RA0;
      REQ_NODE_INIT:    pc = nok ? UPC_NI1 : UPC_DONE;
      REQ_NEIGHBOURS:   pc = npool ? UPC_NB1 : UPC_DONE;
      default:          pc = UPC_DONE;
    endcase
    return pc;
  endfunction

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '0;
    case (pc)
      UPC_FETCH: begin
        w.seq = SEQ_DISPATCH;
      end
      UPC_AF1: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_N;  w.op.nw_data = SRC_HN;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_N;  w.op.pw_data = SRC_ZERO;
      end
      UPC_AF2: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_ZERO; w.op.nw_data = SRC_N;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_HN;   w.op.pw_data = SRC_N;
        w.op.cnt_op = CNT_INC;
        w.seq = SEQ_GOTO; w.target = UPC_DONE;
      end
      UPC_AL1: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_N;  w.op.nw_data = SRC_ZERO;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_N;  w.op.pw_data = SRC_HP;
      end
      UPC_AL2: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_HP;   w.op.nw_data = SRC_N;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_ZERO; w.op.pw_data = SRC_N;
        w.op.cnt_op = CNT_INC;
        w.seq = SEQ_GOTO; w.target = UPC_DONE;
      end
      UPC_RF1: begin
        w.op.rd_src = SRC_HN;
        w.op.res_op = RES_REMOVED;
      end
      UPC_RF2: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_ZERO; w.op.nw_data = SRC_RDN;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_RDN;  w.op.pw_data = SRC_ZERO;
        w.op.cnt_op = CNT_DEC;
        w.seq = SEQ_GOTO; w.target = UPC_DONE;
      end
      UPC_RFE: begin
        w.op.res_op = RES_EMPTY;
        w.seq = SEQ_GOTO; w.target = UPC_DONE;
      end
      UPC_IA1: begin
        w.op.rd_src = SRC_A;
      end
      UPC_IA2: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_N; w.op.nw_data = SRC_RDN;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_N; w.op.pw_data = SRC_A;
        w.op.t_ld = 1'b1;  w.op.t_src = SRC_RDN;
      end
      UPC_IA3: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_A; w.op.nw_data = SRC_N;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_Y; w.op.pw_data = SRC_N;
        w.op.cnt_op = CNT_INC;
        w.seq = SEQ_GOTO; w.target = UPC_DONE;
      end
      UPC_UL1: begin
        w.op.rd_src = SRC_N;
      end
      UPC_UL2: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_RDP; w.op.nw_data = SRC_RDN;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_RDN; w.op.pw_data = SRC_RDP;
        w.op.cnt_op = CNT_DEC;
        w.seq = SEQ_GOTO; w.target = UPC_DONE;
      end
      UPC_RA0: begin
        w.op.t_ld = 1'b1; w.op.t_src = SRC_HN;
        w.op.k_ld = 1'b1;
      end
      UPC_RA1: begin
        w.op.rd_src = SRC_T;
        w.seq = SEQ_KZERO; w.target = UPC_RA3;
      end
      UPC_RA2: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_T; w.op.nw_data = SRC_T;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_T; w.op.pw_data = SRC_T;
        w.op.t_ld = 1'b1;  w.op.t_src = SRC_RDN;
        w.op.k_dec = 1'b1;
        w.seq = SEQ_GOTO; w.target = UPC_RA1;
      end
      UPC_RA3: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_ZERO; w.op.nw_data = SRC_ZERO;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_ZERO; w.op.pw_data = SRC_ZERO;
        w.op.cnt_op = CNT_CLR;
        w.seq = SEQ_GOTO; w.target = UPC_DONE;
      end
      UPC_NI1: begin
        w.op.nw_en = 1'b1; w.op.nw_addr = SRC_N; w.op.nw_data = SRC_N;
        w.op.pw_en = 1'b1; w.op.pw_addr = SRC_N; w.op.pw_data = SRC_N;
        w.seq = SEQ_GOTO; w.target = UPC_DONE;
      end
      UPC_NB1: begin
        w.op.rd_src = SRC_N;
      end
      UPC_NB2: begin
        w.op.res_op = RES_NBR;
      end
      UPC_DONE: begin
        w.seq = SEQ_RETIRE;
      end
      default: begin
        w.seq = SEQ_GOTO; w.target = UPC_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/dllm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Read returns the contents before a write at the same edge. No dependencies.
module dllm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/dllm_useq.sv
// Microprogram sequencer: step counter, control store lookup and jumps.
// Depends on dllm_pkg for the ROM, the dispatch table and the control types.
module dllm_useq #(
  parameter int unsigned POOL_NODES = dllm_pkg::POOL_NODES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  dllm_pkg::req_e       req_type_i,
  input  dllm_pkg::node_t      node_i,
  input  dllm_pkg::node_t      anchor_i,
  input  dllm_pkg::stat_t      stat_i,
  input  logic                 out_free_i,
  output logic                 in_ready_o,
  output logic                 out_ld_o,
  output dllm_pkg::ctl_t       ctl_o
);
  import dllm_pkg::*;

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   accept;

  assign uw         = ucode(upc_q);
  assign in_ready_o = (upc_q == UPC_FETCH) && !stat_i.busy;
  assign accept     = in_valid_i && in_ready_o;
  assign out_ld_o   = (uw.seq == SEQ_RETIRE) && out_free_i;

  assign ctl_o.fetch = accept;
  assign ctl_o.op    = uw.op;

  always_comb begin
    case (uw.seq)
      SEQ_NEXT:     upc_d = upc_q + 1'b1;
      SEQ_GOTO:     upc_d = uw.target;
      SEQ_KZERO:    upc_d = stat_i.k_zero ? uw.target : upc_q + 1'b1;
      SEQ_DISPATCH: upc_d = accept ? dispatch(req_type_i, in_pool(node_i, POOL_NODES),
                                              in_pool(anchor_i, POOL_NODES),
                                              node_i == '0, stat_i.cnt_zero)
                                   : upc_q;
      SEQ_RETIRE:   upc_d = out_free_i ? UPC_FETCH : upc_q;
      default:      upc_d = UPC_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// File: src/dllm_dpath.sv
// Datapath: link RAMs, head shadows, work registers, count and result fields.
// Runs the post-reset clearing pass. Depends on dllm_pkg and dllm_ram.
module dllm_dpath #(
  parameter int unsigned POOL_NODES = dllm_pkg::POOL_NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dllm_pkg::ctl_t   ctl_i,
  input  dllm_pkg::node_t  node_i,
  input  dllm_pkg::node_t  anchor_i,
  output dllm_pkg::stat_t  stat_o,
  output dllm_pkg::res_t   res_o
);
  import dllm_pkg::*;

  localparam int unsigned ADDR_W = $clog2(POOL_NODES);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(POOL_NODES - 1);

  node_t n_q, a_q, t_q, k_q, cnt_q, hn_q, hp_q;
  node_t node_o_q, next_o_q;
  logic  empty_q;
  logic  clr_busy_q;
  logic [ADDR_W-1:0] clr_idx_q;

  node_t rdn, rdp, y_sel;
  node_t nw_addr_v, nw_data_v, pw_addr_v, pw_data_v, rd_addr_v, t_v;
  logic  n_we, p_we;
  logic [ADDR_W-1:0] n_waddr, p_waddr, raddr;
  node_t n_wdata, p_wdata;

  function automatic node_t pick(src_e s, node_t n, node_t a, node_t t, node_t hn,
                                 node_t hp, node_t rn, node_t rp, node_t y);
    node_t v;
    case (s)
      SRC_ZERO: v = '0;
      SRC_N:    v = n;
      SRC_A:    v = a;
      SRC_T:    v = t;
      SRC_HN:   v = hn;
      SRC_HP:   v = hp;
      SRC_RDN:  v = rn;
      SRC_RDP:  v = rp;
      SRC_Y:    v = y;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign y_sel = (a_q == n_q) ? n_q : t_q;

  assign nw_addr_v = pick(ctl_i.op.nw_addr, n_q, a_q, t_q, hn_q, hp_q, rdn, rdp, y_sel);
  assign nw_data_v = pick(ctl_i.op.nw_data, n_q, a_q, t_q, hn_q, hp_q, rdn, rdp, y_sel);
  assign pw_addr_v = pick(ctl_i.op.pw_addr, n_q, a_q, t_q, hn_q, hp_q, rdn, rdp, y_sel);
  assign pw_data_v = pick(ctl_i.op.pw_data, n_q, a_q, t_q, hn_q, hp_q, rdn, rdp, y_sel);
  assign rd_addr_v = pick(ctl_i.op.rd_src, n_q, a_q, t_q, hn_q, hp_q, rdn, rdp, y_sel);
  assign t_v       = pick(ctl_i.op.t_src, n_q, a_q, t_q, hn_q, hp_q, rdn, rdp, y_sel);

  assign n_we    = clr_busy_q || ctl_i.op.nw_en;
  assign p_we    = clr_busy_q || ctl_i.op.pw_en;
  assign n_waddr = clr_busy_q ? clr_idx_q : ADDR_W'(nw_addr_v);
  assign p_waddr = clr_busy_q ? clr_idx_q : ADDR_W'(pw_addr_v);
  assign n_wdata = clr_busy_q ? NODE_W'(clr_idx_q) : nw_data_v;
  assign p_wdata = clr_busy_q ? NODE_W'(clr_idx_q) : pw_data_v;
  assign raddr   = ADDR_W'(rd_addr_v);

  dllm_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (raddr),
    .rdata_o (rdn)
  );

  dllm_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (raddr),
    .rdata_o (rdp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      cnt_q      <= '0;
      hn_q       <= '0;
      hp_q       <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == CLR_LAST) begin
          clr_busy_q <= 1'b0;
        end
      end else begin
        if (ctl_i.op.nw_en && nw_addr_v == '0) begin
          hn_q <= nw_data_v;
        end
        if (ctl_i.op.pw_en && pw_addr_v == '0) begin
          hp_q <= pw_data_v;
        end
      end
      case (ctl_i.op.cnt_op)
        CNT_INC: cnt_q <= cnt_q + 1'b1;
        CNT_DEC: cnt_q <= cnt_q - 1'b1;
        CNT_CLR: cnt_q <= '0;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fetch) begin
      n_q      <= in_pool(node_i, POOL_NODES) ? node_i : '0;
      a_q      <= in_pool(anchor_i, POOL_NODES) ? anchor_i : '0;
      node_o_q <= '0;
      next_o_q <= '0;
      empty_q  <= 1'b0;
    end else begin
      case (ctl_i.op.res_op)
        RES_REMOVED: node_o_q <= hn_q;
        RES_NBR: begin
          node_o_q <= (rdp == n_q) ? '0 : rdp;
          next_o_q <= (rdn == n_q) ? '0 : rdn;
        end
        RES_EMPTY: empty_q <= 1'b1;
        default: ;
      endcase
    end
    if (ctl_i.op.t_ld) begin
      t_q <= t_v;
    end
    if (ctl_i.op.k_ld) begin
      k_q <= cnt_q;
    end else if (ctl_i.op.k_dec) begin
      k_q <= k_q - 1'b1;
    end
  end

  assign stat_o.busy     = clr_busy_q;
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.k_zero   = (k_q == '0);

  assign res_o.node_out   = node_o_q;
  assign res_o.next_out   = next_o_q;
  assign res_o.first_node = (cnt_q != '0) ? hn_q : '0;
  assign res_o.last_node  = (cnt_q != '0) ? hp_q : '0;
  assign res_o.node_count = cnt_q;
  assign res_o.empty_flag = empty_q;

endmodule

// File: src/doubly_linked_list_manager_core.sv
// Circular doubly linked list manager over a fixed node pool, top level.
// Depends on dllm_pkg, dllm_useq and dllm_dpath.
//
// Requests arrive on the s_axis channel, one word per request; each yields
// exactly one result word on the m_axis channel, in request order.
// A request is run by a microprogram; its steps read or rewrite the next
// and prev link RAMs (one write port and one registered read port each).
// The remove_all request runs a read-then-relink loop over the next RAM, once
// per member of the list. A new request is taken the cycle after the result is
// loaded into the output register.
// After reset a clearing pass self-links every entry; s_axis_tready stays low
// until it ends.
// The result sits in an output register; while the receiver stalls, the
// block keeps working on the next request and holds only at its final step.
module doubly_linked_list_manager_core #(
  parameter int unsigned POOL_NODES = dllm_pkg::POOL_NODES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // node_index[5:0], anchor_index[11:6], zero[15:12]
  input  logic [dllm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // req_type[2:0]
  input  logic [dllm_pkg::REQ_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // node_out[5:0], next_out[11:6], first_node[17:12], last_node[23:18],
  // node_count[29:24], zero[31:30]
  output logic [dllm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // empty_flag[0]
  output logic [0:0]                       m_axis_tuser
);
  import dllm_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  res_t  res;
  logic  out_ld, out_free;
  logic  m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic  m_user_q;
  node_t req_node, req_anchor;
  req_e  req_kind;

  assign req_node   = s_axis_tdata[NODE_W-1:0];
  assign req_anchor = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign req_kind   = req_e'(s_axis_tuser);
  assign out_free   = !m_valid_q || m_axis_tready;

  dllm_useq #(.POOL_NODES(POOL_NODES)) u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .req_type_i (req_kind),
    .node_i     (req_node),
    .anchor_i   (req_anchor),
    .stat_i     (stat),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .out_ld_o   (out_ld),
    .ctl_o      (ctl)
  );

  dllm_dpath #(.POOL_NODES(POOL_NODES)) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .node_i   (req_node),
    .anchor_i (req_anchor),
    .stat_o   (stat),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ld) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      m_data_q <= {(M_TDATA_W - 5 * NODE_W)'(0), res.node_count, res.last_node,
                   res.first_node, res.next_out, res.node_out};
      m_user_q <= res.empty_flag;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

endmodule

// File: src/dllm_checker.sv
// Port-level checker for the linked list manager, bound to the top level.
// Depends on dllm_pkg and doubly_linked_list_manager_core.
module dllm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [dllm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);
  import dllm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one still running");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[29:24] == 6'd0) |->
      (m_axis_tdata[17:12] == 6'd0) && (m_axis_tdata[23:18] == 6'd0))
    else $error("empty list reports a first or last node");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[29:24] == 6'd0) && (m_axis_tdata[5:0] == 6'd0))
    else $error("empty flag with members or a removed node");

endmodule

bind doubly_linked_list_manager_core dllm_checker u_dllm_checker (.*);

// File: verif/tb_doubly_linked_list_manager_core.sv
// Testbench for doubly_linked_list_manager_core: drives list requests and checks
// each result word against a behavioral model of the circular list.
// Depends on dllm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_doubly_linked_list_manager_core;
  import dllm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 160;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // node_index[5:0], anchor_index[11:6], zero[15:12]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // req_type[2:0]
  logic [REQ_W-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // node_out[5:0], next_out[11:6], first_node[17:12], last_node[23:18],
  // node_count[29:24], zero[31:30]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // empty_flag[0]
  logic [0:0]           m_axis_tuser;

  node_t       nxt_lnk [64];
  node_t       prv_lnk [64];
  node_t       members_cnt;
  res_t        list_status_q [$];
  bit   [63:0] on_list;
  int unsigned errors;
  int unsigned cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned rx_hold_len;

  doubly_linked_list_manager_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, list_status_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic list_apply(input req_e kind, input node_t n, input node_t a, output res_t r);
    node_t       t;
    node_t       f;
    int unsigned i;
    r = '0;
    case (kind)
      REQ_ADD_FIRST: if (n != '0) begin
        f = nxt_lnk[0];
        prv_lnk[n] = '0;
        nxt_lnk[n] = f;
        prv_lnk[f] = n;
        nxt_lnk[0] = n;
        members_cnt = members_cnt + 1'b1;
      end
      REQ_ADD_LAST: if (n != '0) begin
        t = prv_lnk[0];
        nxt_lnk[n] = '0;
        prv_lnk[n] = t;
        nxt_lnk[t] = n;
        prv_lnk[0] = n;
        members_cnt = members_cnt + 1'b1;
      end
      REQ_REMOVE_FIRST: if (members_cnt == '0) begin
        r.empty_flag = 1'b1;
      end else begin
        r.node_out = nxt_lnk[0];
        f = nxt_lnk[r.node_out];
        nxt_lnk[0] = f;
        prv_lnk[f] = '0;
        members_cnt = members_cnt - 1'b1;
      end
      REQ_INSERT_AFTER: if (n != '0) begin
        prv_lnk[n] = a;
        nxt_lnk[n] = nxt_lnk[a];
        nxt_lnk[a] = n;
        prv_lnk[nxt_lnk[n]] = n;
        members_cnt = members_cnt + 1'b1;
      end
      REQ_UNLINK: if (n != '0) begin
        nxt_lnk[prv_lnk[n]] = nxt_lnk[n];
        prv_lnk[nxt_lnk[n]] = prv_lnk[n];
        members_cnt = members_cnt - 1'b1;
      end
      REQ_REMOVE_ALL: begin
        t = nxt_lnk[0];
        for (i = 0; i < members_cnt; i++) begin
          f = nxt_lnk[t];
          nxt_lnk[t] = t;
          prv_lnk[t] = t;
          t = f;
        end
        nxt_lnk[0] = '0;
        prv_lnk[0] = '0;
        members_cnt = '0;
      end
      REQ_NODE_INIT: if (n != '0) begin
        nxt_lnk[n] = n;
        prv_lnk[n] = n;
      end
      default: begin
        r.node_out = (prv_lnk[n] == n) ? '0 : prv_lnk[n];
        r.next_out = (nxt_lnk[n] == n) ? '0 : nxt_lnk[n];
      end
    endcase
    r.first_node = (members_cnt != '0) ? nxt_lnk[0] : '0;
    r.last_node  = (members_cnt != '0) ? prv_lnk[0] : '0;
    r.node_count = members_cnt;
  endtask

  task automatic send_req(input req_e kind, input node_t n, input node_t a);
    int unsigned gap;
    res_t        r;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({a, n});
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    list_apply(kind, n, a, r);
    list_status_q.push_back(r);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin : receiver
      int unsigned stall;
      @(negedge clk_i);
      stall = rx_idle_en ? $urandom_range(0, 15) : 0;
      if (rx_hold_len > 0) begin
        stall = rx_hold_len;
        rx_hold_len = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic check_field(input string label, input node_t want, input node_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (list_status_q.size() == 0) begin
        errors++;
        $display("%0t: result word with no request pending, expected none actual %h",
                 $time, m_axis_tdata);
      end else begin
        want = list_status_q.pop_front();
        check_field("node_out",   want.node_out,   m_axis_tdata[5:0]);
        check_field("next_out",   want.next_out,   m_axis_tdata[11:6]);
        check_field("first_node", want.first_node, m_axis_tdata[17:12]);
        check_field("last_node",  want.last_node,  m_axis_tdata[23:18]);
        check_field("node_count", want.node_count, m_axis_tdata[29:24]);
        check_field("empty_flag", node_t'(want.empty_flag), node_t'(m_axis_tuser));
      end
    end
  end

  function automatic node_t pick_node(input bit want_member);
    int unsigned start;
    int unsigned j;
    node_t       c;
    start = $urandom_range(1, 63);
    for (j = 0; j < 63; j++) begin
      c = node_t'(((start - 1 + j) % 63) + 1);
      if (on_list[c] == want_member) return c;
    end
    return '0;
  endfunction

  task automatic test_empty_list();
    send_req(REQ_NEIGHBOURS, 6'd5, 6'd0);
    send_req(REQ_NEIGHBOURS, 6'd0, 6'd63);
    send_req(REQ_REMOVE_FIRST, 6'd0, 6'd0);
    send_req(REQ_REMOVE_ALL, 6'd63, 6'd63);
  endtask

  task automatic test_build_and_query();
    send_req(REQ_ADD_FIRST, 6'd1, 6'd0);
    send_req(REQ_ADD_LAST, 6'd63, 6'd0);
    send_req(REQ_INSERT_AFTER, 6'd10, 6'd0);
    send_req(REQ_INSERT_AFTER, 6'd20, 6'd63);
    send_req(REQ_INSERT_AFTER, 6'd30, 6'd30);
    send_req(REQ_NEIGHBOURS, 6'd63, 6'd0);
    send_req(REQ_NEIGHBOURS, 6'd30, 6'd0);
    send_req(REQ_UNLINK, 6'd63, 6'd0);
    send_req(REQ_REMOVE_FIRST, 6'd0, 6'd0);
    send_req(REQ_NEIGHBOURS, 6'd10, 6'd0);
    send_req(REQ_NODE_INIT, 6'd30, 6'd0);
    send_req(REQ_REMOVE_ALL, 6'd0, 6'd0);
  endtask

  task automatic test_head_guard();
    send_req(REQ_ADD_FIRST, 6'd0, 6'd0);
    send_req(REQ_ADD_LAST, 6'd0, 6'd0);
    send_req(REQ_INSERT_AFTER, 6'd0, 6'd5);
    send_req(REQ_UNLINK, 6'd0, 6'd0);
    send_req(REQ_NODE_INIT, 6'd0, 6'd0);
  endtask

  task automatic test_count_wrap();
    send_req(REQ_UNLINK, 6'd5, 6'd0);
    send_req(REQ_NEIGHBOURS, 6'd0, 6'd0);
    send_req(REQ_REMOVE_ALL, 6'd0, 6'd0);
    send_req(REQ_UNLINK, 6'd7, 6'd0);
    send_req(REQ_ADD_FIRST, 6'd9, 6'd0);
    send_req(REQ_REMOVE_ALL, 6'd0, 6'd0);
  endtask

  task automatic test_backpressure();
    int unsigned k;
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_len = 400;
    for (k = 1; k <= 12; k++) send_req(REQ_ADD_LAST, node_t'(k * 5), node_t'(k));
    send_req(REQ_NEIGHBOURS, 6'd30, 6'd0);
    send_req(REQ_REMOVE_ALL, 6'd0, 6'd0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done_cnt;
    int unsigned round_len;
    int unsigned k;
    int unsigned roll;
    int unsigned mode;
    req_e        kind;
    node_t       n;
    node_t       a;
    node_t       first_before;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      mode = $urandom_range(0, 3);
      tx_idle_en = mode[0];
      rx_idle_en = mode[1];
      send_req(REQ_REMOVE_ALL, node_t'($urandom), node_t'($urandom));
      on_list = '0;
      round_len = $urandom_range(10, 70);
      for (k = 0; k < round_len; k++) begin
        a = node_t'($urandom);
        n = node_t'($urandom);
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 12) begin
          kind = req_e'($urandom_range(0, 7));
        end else if (roll < 20) begin
          kind = REQ_ADD_FIRST;
          n = pick_node(1'b0);
        end else if (roll < 40) begin
          kind = REQ_ADD_LAST;
          n = pick_node(1'b0);
        end else if (roll < 55) begin
          kind = REQ_INSERT_AFTER;
          n = pick_node(1'b0);
          a = $urandom_range(0, 1) ? pick_node(1'b1) : '0;
        end else if (roll < 67) begin
          kind = REQ_UNLINK;
          n = pick_node(1'b1);
        end else if (roll < 77) begin
          kind = REQ_REMOVE_FIRST;
        end else if (roll < 87) begin
          kind = REQ_NEIGHBOURS;
        end else if (roll < 94) begin
          kind = REQ_NODE_INIT;
          n = pick_node(1'b0);
        end else if (roll < 96) begin
          kind = REQ_REMOVE_ALL;
        end else begin
          kind = REQ_NEIGHBOURS;
          n = '0;
        end
        if (n == '0 && kind inside {REQ_ADD_FIRST, REQ_ADD_LAST, REQ_INSERT_AFTER,
                                     REQ_UNLINK, REQ_NODE_INIT}) begin
          if ($urandom_range(0, 9) != 0) kind = REQ_REMOVE_FIRST;
        end
        first_before = (members_cnt != '0) ? nxt_lnk[0] : '0;
        send_req(kind, n, a);
        case (kind)
          REQ_ADD_FIRST, REQ_ADD_LAST, REQ_INSERT_AFTER: if (n != '0) on_list[n] = 1'b1;
          REQ_UNLINK, REQ_NODE_INIT: on_list[n] = 1'b0;
          REQ_REMOVE_FIRST: on_list[first_before] = 1'b0;
          REQ_REMOVE_ALL: on_list = '0;
          default: ;
        endcase
        if (!(n == '0 && kind inside {REQ_ADD_FIRST, REQ_ADD_LAST, REQ_INSERT_AFTER,
                                       REQ_UNLINK, REQ_NODE_INIT})) done_cnt++;
      end
    end
  endtask

  initial begin
    int unsigned i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    errors        = 0;
    cycles        = 0;
    rx_hold_len   = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    on_list       = '0;
    members_cnt   = '0;
    for (i = 0; i < 64; i++) begin
      nxt_lnk[i] = node_t'(i);
      prv_lnk[i] = node_t'(i);
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_build_and_query();
    test_head_guard();
    test_count_wrap();
    test_backpressure();
    test_random_traffic(1350);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (list_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
